>>> hdl/tcw_pkg.sv
package tcw_pkg;

  // Request modes carried in the low bits of the input beat.
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Control characters that the put path interprets.
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Tab stops fall on multiples of this many columns.
  localparam int TAB_STOP = 8;

  // Power-up content of every cell: a blank, grey on black.
  localparam logic [15:0] BLANK_CELL = 16'h0720;

  // Attribute register value after reset.
  localparam logic [7:0] ATTR_RESET = 8'd7;

  // Field widths of the beats.
  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = 11;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int POS_W      = 11;
  localparam int CELL_W     = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_WRITE,
    S_READ_WAIT,
    S_SCROLL_RD,
    S_SCROLL_WR,
    S_BLANK,
    S_FILL,
    S_DONE
  } state_t;

endpackage

>>> hdl/text_console_writer_unit.sv
// Text console writer: owns a ROWS x COLUMNS store of 16-bit cells
// (attribute in the high byte, character in the low byte) and a cursor.
// Requests arrive as beats on s_axis: put a character, read a cell or
// clear the screen. Each request produces exactly one beat on m_axis that
// reports the cursor after the request and, for a read, the cell value.
// The attribute used for written and blanked cells is set through
// cfg_wr_en / cfg_wr_data; the user must write it only while no request
// is in flight, which the block does not enforce. One request is in work
// at a time; s_axis_tready is high only while the sequencer is idle. A
// plain character, a backspace that moves or a read passes from exec
// through the write or read-wait state, while newline, return, tab,
// backspace at column zero and mode three skip that step; in done the
// result is loaded into the output register and the sequencer returns to
// idle. A step past the last row scrolls the store through its read and
// write ports, a read and a write for each moved cell, then blanks the
// last row. Clear fills the store at one cell per cycle.
// After reset a fill pass writes the blank cell into all ROWS*COLUMNS
// entries, one per cycle, before the first request is taken.
// When the receiver stalls, the result waits in the output register; one
// further request may be accepted and run, then holds until that slot frees.
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration: attribute byte.
  input  logic                             cfg_wr_en,
  input  logic [7:0]                       cfg_wr_data,
  // Request beats.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: mode[1:0], char_code[9:2], read_address[20:10], zero pad.
  input  logic [tcw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Result beats.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: cursor_row[4:0], cursor_column[11:5],
  // cursor_position[22:12], read_data[38:23], zero pad.
  output logic [tcw_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + tcw_pkg::TAB_STOP);

  // Registers.
  tcw_pkg::state_t state, state_next;
  logic [RW-1:0]   row, row_next;
  logic [CW-1:0]   col, col_next;
  logic [AW-1:0]   idx, idx_next;
  logic [7:0]      attribute;
  logic [tcw_pkg::MODE_W-1:0] req_mode;
  logic [tcw_pkg::CHAR_W-1:0] req_char;
  logic [tcw_pkg::ADDR_W-1:0] req_addr;
  logic [tcw_pkg::CELL_W-1:0] read_data;
  logic                       out_valid;
  logic [tcw_pkg::OUT_DATA_W-1:0] out_data;

  // Screen store.
  logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic [tcw_pkg::CELL_W-1:0] wdata;

  // Sequencer strobes.
  logic in_accept;
  logic load_out;
  logic capture_read;
  logic clear_read;

  // Shared address unit: linear position of the cursor.
  logic [AW-1:0] pos;
  logic          at_bottom;
  logic [CW-1:0] tab_col;
  logic [CW-1:0] col_inc;
  logic          addr_in_range;
  logic [tcw_pkg::CELL_W-1:0] space_cell;

  assign pos        = AW'(row) * AW'(COLUMNS) + AW'(col);
  assign at_bottom  = (row == RW'(ROWS - 1));
  assign tab_col    = (col + CW'(tcw_pkg::TAB_STOP)) & ~CW'(tcw_pkg::TAB_STOP - 1);
  assign col_inc    = col + CW'(1);
  assign addr_in_range = (int'(req_addr) < CELLS);
  assign space_cell = {attribute, tcw_pkg::CH_SPACE};

  assign s_axis_tready = (state == tcw_pkg::S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Next state, cursor update and memory port control.
  always_comb begin
    state_next   = state;
    row_next     = row;
    col_next     = col;
    idx_next     = idx;
    we           = 1'b0;
    waddr        = pos;
    wdata        = space_cell;
    raddr        = AW'(req_addr);
    load_out     = 1'b0;
    capture_read = 1'b0;
    clear_read   = 1'b0;
    unique case (state)
      tcw_pkg::S_INIT: begin
        we    = 1'b1;
        waddr = idx;
        wdata = tcw_pkg::BLANK_CELL;
        if (idx == AW'(CELLS - 1)) begin
          idx_next   = '0;
          state_next = tcw_pkg::S_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      tcw_pkg::S_IDLE: begin
        if (in_accept) begin
          state_next = tcw_pkg::S_EXEC;
        end
      end
      tcw_pkg::S_EXEC: begin
        clear_read = 1'b1;
        state_next = tcw_pkg::S_DONE;
        priority if (req_mode == tcw_pkg::MODE_PUT) begin
          priority if (req_char == tcw_pkg::CH_NEWLINE ||
                       (req_char == tcw_pkg::CH_TAB && tab_col >= CW'(COLUMNS))) begin
            col_next = '0;
            if (at_bottom) begin
              idx_next   = '0;
              state_next = tcw_pkg::S_SCROLL_RD;
            end else begin
              row_next = row + RW'(1);
            end
          end else if (req_char == tcw_pkg::CH_RETURN) begin
            col_next = '0;
          end else if (req_char == tcw_pkg::CH_TAB) begin
            col_next = tab_col;
          end else if (req_char == tcw_pkg::CH_BACKSPACE) begin
            if (col != '0) begin
              col_next   = col - CW'(1);
              state_next = tcw_pkg::S_WRITE;
            end
          end else begin
            state_next = tcw_pkg::S_WRITE;
          end
        end else if (req_mode == tcw_pkg::MODE_READ) begin
          state_next = tcw_pkg::S_READ_WAIT;
        end else if (req_mode == tcw_pkg::MODE_CLEAR) begin
          idx_next   = '0;
          row_next   = '0;
          col_next   = '0;
          state_next = tcw_pkg::S_FILL;
        end else begin
          state_next = tcw_pkg::S_DONE;
        end
      end
      tcw_pkg::S_WRITE: begin
        // Backspace blanks the cell it moved onto; other bytes are stored.
        we         = 1'b1;
        state_next = tcw_pkg::S_DONE;
        if (req_char == tcw_pkg::CH_BACKSPACE) begin
          wdata = space_cell;
        end else begin
          wdata = {attribute, req_char};
          if (col_inc >= CW'(COLUMNS)) begin
            col_next = '0;
            if (at_bottom) begin
              idx_next   = '0;
              state_next = tcw_pkg::S_SCROLL_RD;
            end else begin
              row_next = row + RW'(1);
            end
          end else begin
            col_next = col_inc;
          end
        end
      end
      tcw_pkg::S_READ_WAIT: begin
        capture_read = addr_in_range;
        state_next   = tcw_pkg::S_DONE;
      end
      tcw_pkg::S_SCROLL_RD: begin
        raddr      = idx + AW'(COLUMNS);
        state_next = tcw_pkg::S_SCROLL_WR;
      end
      tcw_pkg::S_SCROLL_WR: begin
        we    = 1'b1;
        waddr = idx;
        wdata = rdata;
        idx_next = idx + AW'(1);
        if (idx == AW'(CELLS - COLUMNS - 1)) begin
          state_next = tcw_pkg::S_BLANK;
        end else begin
          state_next = tcw_pkg::S_SCROLL_RD;
        end
      end
      tcw_pkg::S_BLANK, tcw_pkg::S_FILL: begin
        we    = 1'b1;
        waddr = idx;
        wdata = space_cell;
        if (idx == AW'(CELLS - 1)) begin
          idx_next   = '0;
          state_next = tcw_pkg::S_DONE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      tcw_pkg::S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = tcw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcw_pkg::S_INIT;
      row       <= '0;
      col       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
      attribute <= tcw_pkg::ATTR_RESET;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      idx   <= idx_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        attribute <= cfg_wr_data;
      end
    end
  end

  // Request fields, read result and output beat.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_mode <= s_axis_tdata[1:0];
      req_char <= s_axis_tdata[9:2];
      req_addr <= s_axis_tdata[20:10];
    end
    if (clear_read) begin
      read_data <= '0;
    end else if (capture_read) begin
      read_data <= rdata;
    end
    if (load_out) begin
      out_data <= {1'b0, read_data, tcw_pkg::POS_W'(pos),
                   tcw_pkg::COL_W'(col), tcw_pkg::ROW_W'(row)};
    end
  end

  // Screen store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
